// ----- sv/rv64x_pkg.sv -----
// rv64x_pkg: shared types, codes and the instruction decoder of the RV64 subset execute unit.
// Used by rv64x_regfile, rv64x_dmem and rv64_subset_execute_unit; depends on nothing.
`default_nettype none

package rv64x_pkg;

  // Default data memory size in bytes (a power of two)
  localparam int unsigned MEM_BYTES_DEF = 65536;

  localparam int unsigned XLEN   = 64;
  localparam int unsigned NREGS  = 32;
  localparam int unsigned REG_AW = 5;

  // Command codes
  typedef enum logic [1:0] {
    CMD_EXEC   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RD_ZERO     = 2'd1,
    ST_RS2_ZERO    = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_e;

  // Major opcodes and function codes
  localparam logic [6:0] OP_REG   = 7'b0110011;
  localparam logic [6:0] OP_IMM   = 7'b0010011;
  localparam logic [6:0] OP_LOAD  = 7'b0000011;
  localparam logic [6:0] OP_STORE = 7'b0100011;
  localparam logic [2:0] F3_ADD   = 3'd0;
  localparam logic [2:0] F3_DW    = 3'd3;
  localparam logic [6:0] F7_ADD   = 7'h00;
  localparam logic [6:0] F7_SUB   = 7'h20;

  // Data memory access request
  typedef struct packed {
    logic wr;
    logic rd;
  } dmem_cmd_t;

  // Register file write request
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
  } rf_wr_t;

  // Decoded control of one item
  typedef struct packed {
    logic              rd_wr;      // destination register gets written
    logic              alu_sub;    // subtract instead of add
    logic              src_imm;    // second operand is the immediate
    logic              port_addr;  // address and data come from the item fields
    logic              is_load;    // destination value comes from memory
    logic              show_read;  // read data goes out on read_data
    dmem_cmd_t         mem;
    status_e           status;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rs2;
    logic [11:0]       imm;
  } ctl_t;

  // Decode one command and instruction into control
  function automatic ctl_t decode(cmd_e cmd, logic [31:0] insn);
    logic [6:0] opcode;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       is_add;
    logic       is_sub;
    logic       is_addi;
    logic       is_ld;
    logic       is_sd;
    logic       wants_rd;
    ctl_t       c;
    opcode   = insn[6:0];
    f3       = insn[14:12];
    f7       = insn[31:25];
    is_add   = (opcode == OP_REG) && (f3 == F3_ADD) && (f7 == F7_ADD);
    is_sub   = (opcode == OP_REG) && (f3 == F3_ADD) && (f7 == F7_SUB);
    is_addi  = (opcode == OP_IMM) && (f3 == F3_ADD);
    is_ld    = (opcode == OP_LOAD) && (f3 == F3_DW);
    is_sd    = (opcode == OP_STORE) && (f3 == F3_DW);
    wants_rd = is_add || is_sub || is_addi || is_ld;

    c.rd_wr     = 1'b0;
    c.alu_sub   = 1'b0;
    c.src_imm   = 1'b0;
    c.port_addr = 1'b0;
    c.is_load   = 1'b0;
    c.show_read = 1'b0;
    c.mem.wr    = 1'b0;
    c.mem.rd    = 1'b0;
    c.status    = ST_OK;
    c.rd        = insn[11:7];
    c.rs1       = insn[19:15];
    c.rs2       = insn[24:20];
    c.imm       = is_sd ? {insn[31:25], insn[11:7]} : insn[31:20];

    unique case (cmd)
      CMD_WRITE: begin
        c.port_addr = 1'b1;
        c.mem.wr    = 1'b1;
      end
      CMD_READ: begin
        c.port_addr = 1'b1;
        c.mem.rd    = 1'b1;
        c.show_read = 1'b1;
      end
      CMD_EXEC: begin
        c.alu_sub = is_sub;
        c.src_imm = is_addi || is_ld || is_sd;
        if (wants_rd) begin
          if (c.rd == '0) begin
            c.status = ST_RD_ZERO;
          end else begin
            c.rd_wr   = 1'b1;
            c.is_load = is_ld;
            c.mem.rd  = is_ld;
          end
        end else if (is_sd) begin
          if (c.rs2 == '0) begin
            c.status = ST_RS2_ZERO;
          end else begin
            c.mem.wr = 1'b1;
          end
        end else begin
          c.status = ST_UNSUPPORTED;
        end
      end
      default: begin
        c.status = ST_UNSUPPORTED;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rv64x_regfile.sv -----
// rv64x_regfile: 32 x 64 register file, two synchronous read ports and one write port.
// Per-entry valid bits make every entry read as zero after reset. Uses rv64x_pkg.
`default_nettype none

module rv64x_regfile (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             rd_en_i,
  input  wire logic [rv64x_pkg::REG_AW-1:0]     rs1_i,
  input  wire logic [rv64x_pkg::REG_AW-1:0]     rs2_i,
  input  wire rv64x_pkg::rf_wr_t                wr_i,
  input  wire logic [rv64x_pkg::XLEN-1:0]       wdata_i,
  output logic      [rv64x_pkg::XLEN-1:0]       rdata1_o,
  output logic      [rv64x_pkg::XLEN-1:0]       rdata2_o
);

  logic [rv64x_pkg::XLEN-1:0]  mem [rv64x_pkg::NREGS];
  logic [rv64x_pkg::NREGS-1:0] valid_q;
  logic [rv64x_pkg::XLEN-1:0]  rdata1_q;
  logic [rv64x_pkg::XLEN-1:0]  rdata2_q;

  // Mark an entry valid once written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  // Write port and registered reads; an entry never written reads as zero
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata1_q <= valid_q[rs1_i] ? mem[rs1_i] : '0;
      rdata2_q <= valid_q[rs2_i] ? mem[rs2_i] : '0;
    end
  end

  assign rdata1_o = rdata1_q;
  assign rdata2_o = rdata2_q;

endmodule

`default_nettype wire

// ----- sv/rv64x_dmem.sv -----
// rv64x_dmem: byte-addressed data memory as eight byte banks, one doubleword per access.
// Handles unaligned, wrapping addresses; read data one cycle after the request. Uses rv64x_pkg.
`default_nettype none

module rv64x_dmem #(
  parameter  int unsigned MEM_BYTES = rv64x_pkg::MEM_BYTES_DEF,
  localparam int unsigned AW        = $clog2(MEM_BYTES)
) (
  input  wire logic                  clk_i,
  input  wire rv64x_pkg::dmem_cmd_t  cmd_i,
  input  wire logic [AW-1:0]         addr_i,
  input  wire logic [63:0]           wdata_i,
  output logic      [63:0]           rdata_o
);

  localparam int unsigned ROWS  = MEM_BYTES / 8;
  localparam int unsigned ROW_W = (AW > 3) ? AW - 3 : 1;

  logic [2:0] off_q;
  logic [7:0] bank_rd [8];

  // Remember the byte offset of a read for realignment
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      off_q <= addr_i[2:0];
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]      mem [ROWS];
    logic [7:0]      q;
    logic [2:0]      lane;
    logic [AW-1:0]   byte_addr;
    logic [ROW_W-1:0] row;

    // Byte of the doubleword that lands in this bank, and its row
    assign lane      = 3'(b) - addr_i[2:0];
    assign byte_addr = addr_i + AW'(lane);
    assign row       = ROW_W'(byte_addr >> 3);

    always_ff @(posedge clk_i) begin
      if (cmd_i.wr) begin
        mem[row] <= wdata_i[8*lane +: 8];
      end
      if (cmd_i.rd) begin
        q <= mem[row];
      end
    end

    assign bank_rd[b] = q;
  end

  // Rotate the bank outputs back into doubleword order
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rdata_o[8*i +: 8] = bank_rd[off_q + 3'(i)];
    end
  end

endmodule

`default_nettype wire

// ----- sv/rv64_subset_execute_unit.sv -----
// An item passes the execute stage, the memory stage and the output register in turn.
// Throughput: one item per cycle while out_ready_i is high; results of the stage ahead,
// loads included, are forwarded to execute, so dependents run back to back without bubbles.
// The register file read and the data memory bank access are both registered.
// Reset clears the pipeline and the register file valid bits; the data memory keeps its
// contents. MEM_BYTES must be a power of two.
`default_nettype none

module rv64_subset_execute_unit #(
  parameter  int unsigned MEM_BYTES = rv64x_pkg::MEM_BYTES_DEF,
  localparam int unsigned AW        = $clog2(MEM_BYTES)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   cmd_i,
  input  wire logic [31:0]  instruction_word_i,
  input  wire logic [15:0]  mem_address_i,
  input  wire logic [63:0]  write_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [1:0]        status_o,
  output logic              reg_written_o,
  output logic [4:0]        dest_index_o,
  output logic [63:0]       dest_value_o,
  output logic              mem_stored_o,
  output logic [15:0]       effective_address_o,
  output logic [63:0]       read_data_o
);

  // Pipeline control
  logic in_xfer, s1_adv, s2_adv, s2_free, out_free;
  rv64x_pkg::ctl_t in_ctl;

  // Execute stage
  logic            s1_valid_q;
  rv64x_pkg::ctl_t s1_ctl_q;
  logic [15:0]     s1_maddr_q;
  logic [63:0]     s1_wdata_q;
  logic [63:0]     rf_rdata1, rf_rdata2;
  logic [63:0]     op1, op2, alu_b, alu_sum;
  logic [AW-1:0]   s1_addr;
  logic [63:0]     s1_store_data;

  // Memory stage
  logic            s2_valid_q;
  rv64x_pkg::ctl_t s2_ctl_q;
  logic [63:0]     s2_result_q;
  logic [AW-1:0]   s2_addr_q;
  logic [63:0]     s2_value;
  logic [63:0]     dmem_rdata;

  rv64x_pkg::dmem_cmd_t dmem_cmd;
  rv64x_pkg::rf_wr_t    rf_wr;

  // Last register file write, for a read issued at the same edge
  logic        wb_valid_q;
  logic [4:0]  wb_idx_q;
  logic [63:0] wb_val_q;

  // Output register
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic        reg_written_q;
  logic [4:0]  dest_index_q;
  logic [63:0] dest_value_q;
  logic        mem_stored_q;
  logic [15:0] eaddr_q;
  logic [63:0] read_data_q;

  // Advance whenever the stage ahead is free or moving on
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || s2_adv;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_ctl = rv64x_pkg::decode(rv64x_pkg::cmd_e'(cmd_i), instruction_word_i);

  rv64x_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_xfer),
    .rs1_i    (in_ctl.rs1),
    .rs2_i    (in_ctl.rs2),
    .wr_i     (rf_wr),
    .wdata_i  (s2_value),
    .rdata1_o (rf_rdata1),
    .rdata2_o (rf_rdata2)
  );

  // Forward from the memory stage, then from the last write, then the file
  assign s2_value = s2_ctl_q.is_load ? dmem_rdata : s2_result_q;

  always_comb begin
    if (s2_valid_q && s2_ctl_q.rd_wr && (s2_ctl_q.rd == s1_ctl_q.rs1)) begin
      op1 = s2_value;
    end else if (wb_valid_q && (wb_idx_q == s1_ctl_q.rs1)) begin
      op1 = wb_val_q;
    end else begin
      op1 = rf_rdata1;
    end
    if (s2_valid_q && s2_ctl_q.rd_wr && (s2_ctl_q.rd == s1_ctl_q.rs2)) begin
      op2 = s2_value;
    end else if (wb_valid_q && (wb_idx_q == s1_ctl_q.rs2)) begin
      op2 = wb_val_q;
    end else begin
      op2 = rf_rdata2;
    end
  end

  // One add/sub serves ALU results and load/store addresses
  assign alu_b   = s1_ctl_q.src_imm ? {{52{s1_ctl_q.imm[11]}}, s1_ctl_q.imm} : op2;
  assign alu_sum = s1_ctl_q.alu_sub ? (op1 - alu_b) : (op1 + alu_b);

  assign s1_addr       = s1_ctl_q.port_addr ? AW'(s1_maddr_q) : alu_sum[AW-1:0];
  assign s1_store_data = s1_ctl_q.port_addr ? s1_wdata_q : op2;

  // Issue the memory access as the item leaves the execute stage
  always_comb begin
    dmem_cmd = '0;
    if (s1_adv) begin
      dmem_cmd = s1_ctl_q.mem;
    end
  end

  rv64x_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk_i   (clk_i),
    .cmd_i   (dmem_cmd),
    .addr_i  (s1_addr),
    .wdata_i (s1_store_data),
    .rdata_o (dmem_rdata)
  );

  // Commit the destination register as the item retires
  assign rf_wr.en  = s2_adv && s2_ctl_q.rd_wr;
  assign rf_wr.idx = s2_ctl_q.rd;

  // Stage valids and write bypass valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_adv;
      end
      if (out_free) begin
        out_valid_q <= s2_adv;
      end
      if (rf_wr.en) begin
        wb_valid_q <= 1'b1;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ctl_q   <= in_ctl;
      s1_maddr_q <= mem_address_i;
      s1_wdata_q <= write_data_i;
    end
    if (s1_adv) begin
      s2_ctl_q    <= s1_ctl_q;
      s2_result_q <= alu_sum;
      s2_addr_q   <= s1_addr;
    end
    if (rf_wr.en) begin
      wb_idx_q <= rf_wr.idx;
      wb_val_q <= s2_value;
    end
    if (s2_adv) begin
      status_q      <= s2_ctl_q.status;
      reg_written_q <= s2_ctl_q.rd_wr;
      dest_index_q  <= s2_ctl_q.rd_wr ? s2_ctl_q.rd : '0;
      dest_value_q  <= s2_ctl_q.rd_wr ? s2_value : '0;
      mem_stored_q  <= s2_ctl_q.mem.wr;
      eaddr_q       <= (s2_ctl_q.mem.wr || s2_ctl_q.mem.rd) ? 16'(s2_addr_q) : '0;
      read_data_q   <= s2_ctl_q.show_read ? dmem_rdata : '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign reg_written_o       = reg_written_q;
  assign dest_index_o        = dest_index_q;
  assign dest_value_o        = dest_value_q;
  assign mem_stored_o        = mem_stored_q;
  assign effective_address_o = eaddr_q;
  assign read_data_o         = read_data_q;

`ifndef SYNTHESIS
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> rf_wr.idx != '0)
    else $error("register x0 written");

  a_dmem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dmem_cmd.wr && dmem_cmd.rd))
    else $error("data memory read and write in one cycle");

  a_refused_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != rv64x_pkg::ST_OK)) |-> (!reg_written_o && !mem_stored_o))
    else $error("refused item reports an update");

  a_commit_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |=> (out_valid_q && reg_written_q))
    else $error("register commit not reported on the output");
`endif

endmodule

`default_nettype wire
